// ===== hdl/sil_pkg.sv =====
// Shared constants, types and FSM encoding for the sorted insert list unit.
`default_nettype none

package sil_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } sil_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic insert;   // push the input value (dropped if full), restart listing
    logic advance;  // step to the next listed entry
  } sil_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic at_last;  // current listing entry is the final one
  } sil_sts_t;

endpackage

`default_nettype wire

// ===== hdl/sil_in_if.sv =====
// Input channel interface: one value per transfer.
`default_nettype none

interface sil_in_if
  import sil_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/sil_out_if.sv =====
// Output channel interface: one listed entry per transfer.
`default_nettype none

interface sil_out_if
  import sil_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry;
  logic [POS_W-1:0]         position;
  logic                     last;
  logic                     rejected;

  modport source (output valid, output entry, output position, output last,
                  output rejected, input ready);
  modport sink   (input valid, input entry, input position, input last,
                  input rejected, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_insert_list_unit.sv =====
// Top level of the sorted insert list unit.
`default_nettype none

// Sorted insert list unit. Holds up to CAPACITY (16) signed 32-bit values in
// ascending order. Each transfer on in_i pushes one value, which lands after
// every stored value less than or equal to it, so equal values keep arrival
// order. After each push the whole list goes out on out_o, smallest first,
// one transfer per stored entry, with position counting from zero and last
// set on the final entry. A push into a full list is dropped and every
// transfer of that listing carries rejected. On a push all stored entries
// are compared against the value in parallel and shifted into place at
// once; the listing then reads each entry straight from the entry
// registers through the listing pointer mux, and out_o stalls can hold it.
// in_i is not ready while a listing is in progress. No clearing pass after
// reset: only entries below the fill count are ever read.

module sorted_insert_list_unit
  import sil_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sil_in_if.sink    in_i,
  sil_out_if.source out_o
);

  sil_cmd_t cmd;
  sil_sts_t sts;

  // Sequencing: idle until a push, then one listing transfer per entry.
  sil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, insertion network and listing pointer.
  sil_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (in_i.value),
    .sts_o      (sts),
    .entry_o    (out_o.entry),
    .position_o (out_o.position),
    .rejected_o (out_o.rejected)
  );

  assign out_o.last = sts.at_last;

endmodule

`default_nettype wire

// ===== hdl/sil_ctrl.sv =====
// Controller FSM: accepts a push, then walks the listing one transfer per entry.
`default_nettype none

module sil_ctrl
  import sil_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire sil_sts_t sts_i,
  output sil_cmd_t      cmd_o
);

  sil_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.insert  = 1'b0;
    cmd_o.advance = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.at_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Input and output sides never open together.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open in the same cycle");

  // A push always leads straight into a listing.
  a_push_lists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |=> out_valid_o)
    else $error("push not followed by listing");

  // Final transfer of a listing returns to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && sts_i.at_last) |=> in_ready_o)
    else $error("listing did not end after final entry");

endmodule

`default_nettype wire

// ===== hdl/sil_dpath.sv =====
// Datapath: sorted entry registers, fill count, listing pointer, reject flag.
`default_nettype none

module sil_dpath
  import sil_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sil_cmd_t                 cmd_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output sil_sts_t                      sts_o,
  output logic signed [DATA_W-1:0]      entry_o,
  output logic [POS_W-1:0]              position_o,
  output logic                          rejected_o
);

  logic signed [DATA_W-1:0] entries_q [CAPACITY];
  logic signed [DATA_W-1:0] shift_in  [CAPACITY];
  logic [CAPACITY-1:0]      le;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         pos_q;
  logic                     reject_q;
  logic                     full;
  logic                     do_insert;

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign do_insert = cmd_i.insert && !full;

  // le is a prefix mask: stored entries that stay in place on insert.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    assign le[k] = (CNT_W'(k) < count_q) && (entries_q[k] <= value_i);
    if (k == 0) begin : g_head
      assign shift_in[k] = value_i;
    end else begin : g_body
      assign shift_in[k] = le[k-1] ? value_i : entries_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (!le[k]) begin
          entries_q[k] <= shift_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pos_q    <= '0;
      reject_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        reject_q <= full;
        pos_q    <= '0;
        if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (cmd_i.advance) begin
        pos_q <= pos_q + IDX_W'(1);
      end
    end
  end

  assign sts_o.at_last = ((CNT_W'(pos_q) + CNT_W'(1)) == count_q);
  assign entry_o       = entries_q[pos_q];
  assign position_o    = POS_W'(pos_q);
  assign rejected_o    = reject_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + CNT_W'(1)) && !reject_q)
    else $error("accepted push did not grow the list");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.insert && full) |=> (count_q == $past(count_q)) && reject_q)
    else $error("dropped push changed the list");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CNT_W'(pos_q) < count_q))
    else $error("listing pointer beyond fill count");

endmodule

`default_nettype wire
